### rtl/core/mer_pkg.sv
// Shared types and constants of the rotated midpoint ellipse rasterizer.
// Used by every module of the block; depends on nothing else.
`default_nettype none
package mer_pkg;

  localparam int AXIS_WIDTH_DEF = 10;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int DEC_BITS       = 48;
  localparam int OUT_BITS       = 20;
  localparam int CFG_WIDTH      = 16;
  localparam int COEF_FRAC      = 15;
  localparam int OQ_DEPTH       = 8;
  localparam int OCC_W          = $clog2(OQ_DEPTH) + 1;

  localparam logic signed [15:0]          COEF_Q15  = 16'sd23170;
  localparam logic signed [CFG_WIDTH-1:0] CX_RESET  = -16'sd2304;
  localparam logic signed [CFG_WIDTH-1:0] CY_RESET  = 16'sd2304;

  localparam logic REG_CENTER_X = 1'b0;
  localparam logic REG_CENTER_Y = 1'b1;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } cmd_ctl_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic fin;
  } pt_ctl_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] x;
    logic signed [OUT_BITS-1:0] y;
    logic                       last;
    logic                       fin;
  } out_word_t;

endpackage
`default_nettype wire

### rtl/core/mer_front.sv
// Command queue of the rasterizer: takes input words and classifies them.
// Depends on mer_pkg.
`default_nettype none
module mer_front
  import mer_pkg::*;
#(
  parameter int AXIS_WIDTH = AXIS_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic                  in_command,
  input  logic [AXIS_WIDTH-1:0] in_semi_axis_a,
  input  logic [AXIS_WIDTH-1:0] in_semi_axis_b,
  input  logic                  cmd_pop,
  output cmd_ctl_t              cmd_ctl,
  output logic [AXIS_WIDTH-1:0] cmd_a,
  output logic [AXIS_WIDTH-1:0] cmd_b
);

  op_t                   op_q_r [2];
  logic [AXIS_WIDTH-1:0] a_q_r  [2];
  logic [AXIS_WIDTH-1:0] b_q_r  [2];
  logic                  wr_ptr_r, rd_ptr_r;
  logic [1:0]            cnt_r;
  logic                  wr_en, rd_en;

  assign full          = (cnt_r == 2'd2);
  assign wr_en         = push && !full;
  assign rd_en         = cmd_pop && (cnt_r != 2'd0);
  assign cmd_ctl.valid = (cnt_r != 2'd0);
  assign cmd_ctl.op    = op_q_r[rd_ptr_r];
  assign cmd_a         = a_q_r[rd_ptr_r];
  assign cmd_b         = b_q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      op_q_r[wr_ptr_r] <= in_command ? OP_STEP : OP_START;
      a_q_r[wr_ptr_r]  <= in_semi_axis_a;
      b_q_r[wr_ptr_r]  <= in_semi_axis_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_r <= ~wr_ptr_r;
      if (rd_en) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule
`default_nettype wire

### rtl/core/mer_back.sv
// Sequencer of the rasterizer: ellipse set-up, region change and pixel steps,
// with one shared registered multiplier. Depends on mer_pkg.
`default_nettype none
module mer_back
  import mer_pkg::*;
#(
  parameter int AXIS_WIDTH = AXIS_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cmd_ctl_t                     cmd_ctl,
  input  logic [AXIS_WIDTH-1:0]        cmd_a,
  input  logic [AXIS_WIDTH-1:0]        cmd_b,
  output logic                         cmd_pop,
  input  logic [OCC_W-1:0]             occ,
  output pt_ctl_t                      pt_ctl,
  output logic signed [AXIS_WIDTH+2:0] pt_sx,
  output logic signed [AXIS_WIDTH+2:0] pt_sy
);

  localparam int PXW = AXIS_WIDTH + 1;
  localparam int PYW = AXIS_WIDTH + 2;
  localparam int SQW = 2 * AXIS_WIDTH;
  localparam int MW  = 2 * AXIS_WIDTH + 6;
  localparam int SW  = AXIS_WIDTH + 3;

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001, S_SQA = 16'h0002, S_SQB = 16'h0004, S_AB   = 16'h0008,
    S_INIT = 16'h0010, S_TX  = 16'h0020, S_TY  = 16'h0040, S_P1   = 16'h0080,
    S_P2   = 16'h0100, S_P3  = 16'h0200, S_RC  = 16'h0400, S_CHK  = 16'h0800,
    S_EMIT = 16'h1000, S_UPA = 16'h2000, S_UPB = 16'h4000, S_FIN  = 16'h8000
  } state_t;

  state_t                    state_r;
  logic [AXIS_WIDTH-1:0]     a_r, b_r;
  logic [SQW-1:0]            a2_r, b2_r;
  logic [PXW-1:0]            pos_x_r;
  logic signed [PYW-1:0]     pos_y_r;
  logic [DEC_BITS-1:0]       sx_r, sy_r, dec_r;
  logic                      r2_r, act_r;
  logic [MW-1:0]             txx_r, tyy_r;
  logic [2*MW-1:0]           mul_p_r;
  logic [1:0]                k_r;

  logic [MW-1:0]             mul_a, mul_b;
  logic [DEC_BITS-1:0]       prod_d, a2_d, b2_d, abs_x, abs_y;
  logic signed [PYW:0]       ty;
  logic [PYW:0]              ty_mag;
  logic signed [SW-1:0]      px, py;
  logic                      room;

  assign prod_d = DEC_BITS'(mul_p_r);
  assign a2_d   = DEC_BITS'(a2_r);
  assign b2_d   = DEC_BITS'(b2_r);
  assign abs_x  = sx_r[DEC_BITS-1] ? -sx_r : sx_r;
  assign abs_y  = sy_r[DEC_BITS-1] ? -sy_r : sy_r;
  assign ty     = (PYW+1)'(pos_y_r) - (PYW+1)'(1);
  assign ty_mag = ty[PYW] ? (PYW+1)'(-ty) : (PYW+1)'(ty);
  assign room   = ((OCC_W+1)'(occ) + (OCC_W+1)'(4)) <= (OCC_W+1)'(OQ_DEPTH);
  assign cmd_pop = (state_r == S_IDLE) && cmd_ctl.valid && (room || cmd_ctl.op == OP_START);

  assign px    = k_r[0] ? -$signed(SW'(pos_x_r)) : $signed(SW'(pos_x_r));
  assign py    = k_r[1] ? -SW'(pos_y_r) : SW'(pos_y_r);
  assign pt_sx = px - py;
  assign pt_sy = px + py;
  assign pt_ctl.valid = (state_r == S_EMIT) || (state_r == S_FIN);
  assign pt_ctl.last  = (state_r == S_EMIT) && (k_r == 2'd3);
  assign pt_ctl.fin   = (state_r == S_FIN);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SQA: begin mul_a = MW'(a_r); mul_b = MW'(a_r); end
      S_SQB: begin mul_a = MW'(b_r); mul_b = MW'(b_r); end
      S_AB:  begin mul_a = MW'(a2_r); mul_b = MW'(b_r); end
      S_TX:  begin mul_a = MW'({pos_x_r, 1'b1}); mul_b = MW'({pos_x_r, 1'b1}); end
      S_TY:  begin mul_a = MW'(ty_mag); mul_b = MW'(ty_mag); end
      S_P1:  begin mul_a = MW'(b2_r); mul_b = txx_r; end
      S_P2:  begin mul_a = MW'(a2_r); mul_b = tyy_r; end
      S_P3:  begin mul_a = MW'(a2_r); mul_b = MW'(b2_r); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      a_r     <= '0;
      b_r     <= '0;
      a2_r    <= '0;
      b2_r    <= '0;
      pos_x_r <= '0;
      pos_y_r <= '0;
      sx_r    <= '0;
      sy_r    <= '0;
      dec_r   <= '0;
      r2_r    <= 1'b0;
      act_r   <= 1'b0;
      txx_r   <= '0;
      tyy_r   <= '0;
      k_r     <= 2'd0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          k_r <= 2'd0;
          if (cmd_pop) begin
            if (cmd_ctl.op == OP_START) begin
              a_r     <= cmd_a;
              b_r     <= cmd_b;
              state_r <= S_SQA;
            end else if (!act_r) begin
              state_r <= S_FIN;
            end else if (r2_r) begin
              state_r <= S_CHK;
            end else if (abs_x < abs_y) begin
              state_r <= S_EMIT;
            end else begin
              state_r <= S_TX;
            end
          end
        end
        S_SQA: state_r <= S_SQB;
        S_SQB: begin
          a2_r    <= SQW'(mul_p_r);
          state_r <= S_AB;
        end
        S_AB: begin
          b2_r    <= SQW'(mul_p_r);
          state_r <= S_INIT;
        end
        S_INIT: begin
          sy_r    <= prod_d << 1;
          dec_r   <= (b2_d << 2) - (prod_d << 2) + a2_d;
          sx_r    <= '0;
          pos_x_r <= '0;
          pos_y_r <= PYW'(b_r);
          r2_r    <= 1'b0;
          act_r   <= 1'b1;
          state_r <= S_IDLE;
        end
        S_TX: state_r <= S_TY;
        S_TY: begin
          txx_r   <= MW'(mul_p_r);
          state_r <= S_P1;
        end
        S_P1: begin
          tyy_r   <= MW'(mul_p_r);
          state_r <= S_P2;
        end
        S_P2: begin
          dec_r   <= prod_d;
          state_r <= S_P3;
        end
        S_P3: begin
          dec_r   <= dec_r + (prod_d << 2);
          state_r <= S_RC;
        end
        S_RC: begin
          dec_r   <= dec_r - (prod_d << 2);
          r2_r    <= 1'b1;
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (pos_y_r[PYW-1]) begin
            state_r <= S_FIN;
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          k_r <= k_r + 2'd1;
          if (k_r == 2'd3) state_r <= S_UPA;
        end
        S_UPA: begin
          if (!r2_r) begin
            pos_x_r <= pos_x_r + PXW'(1);
            sx_r    <= sx_r + (b2_d << 1);
            if (!dec_r[DEC_BITS-1]) begin
              pos_y_r <= pos_y_r - PYW'(1);
              sy_r    <= sy_r - (a2_d << 1);
            end
          end else begin
            pos_y_r <= pos_y_r - PYW'(1);
            sy_r    <= sy_r - (a2_d << 1);
            if (dec_r[DEC_BITS-1]) begin
              pos_x_r <= pos_x_r + PXW'(1);
              sx_r    <= sx_r + (b2_d << 1);
            end
          end
          state_r <= S_UPB;
        end
        S_UPB: begin
          if (!r2_r) begin
            if (dec_r[DEC_BITS-1]) begin
              dec_r <= dec_r + ((sx_r + b2_d) << 2);
            end else begin
              dec_r <= dec_r + ((sx_r - sy_r + b2_d) << 2);
            end
          end else begin
            if (!dec_r[DEC_BITS-1]) begin
              dec_r <= dec_r + ((a2_d - sy_r) << 2);
            end else begin
              dec_r <= dec_r + ((sx_r - sy_r + a2_d) << 2);
            end
          end
          state_r <= S_IDLE;
        end
        S_FIN: begin
          act_r   <= 1'b0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/core/mer_point.sv
// Point pipeline: 45 degree rotation, rounding, centre offset and saturation.
// Holds the centre registers. Depends on mer_pkg.
`default_nettype none
module mer_point
  import mer_pkg::*;
#(
  parameter int AXIS_WIDTH = AXIS_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_index,
  input  logic [CFG_WIDTH-1:0]         cfg_wdata,
  input  pt_ctl_t                      pt_ctl,
  input  logic signed [AXIS_WIDTH+2:0] pt_sx,
  input  logic signed [AXIS_WIDTH+2:0] pt_sy,
  output logic                         oq_push,
  output out_word_t                    oq_word,
  output logic [1:0]                   busy
);

  localparam int SW  = AXIS_WIDTH + 3;
  localparam int PW  = SW + 16;
  localparam int QW  = PW + 2 + ((FRAC_BITS > COEF_FRAC) ? FRAC_BITS - COEF_FRAC : 0);
  localparam int SHR = (FRAC_BITS <= COEF_FRAC) ? COEF_FRAC - FRAC_BITS : 0;
  localparam int SHL = (FRAC_BITS > COEF_FRAC) ? FRAC_BITS - COEF_FRAC : 0;
  localparam int RND = (SHR > 0) ? (1 << (SHR - 1)) : 0;
  localparam logic signed [QW:0] LIM_HI = (QW+1)'((2 ** (OUT_BITS - 1)) - 1);
  localparam logic signed [QW:0] LIM_LO = (QW+1)'(-(2 ** (OUT_BITS - 1)));

  logic signed [CFG_WIDTH-1:0] cx_r, cy_r;
  pt_ctl_t                     s1_ctl_r, s2_ctl_r;
  logic signed [SW-1:0]        s1_x_r, s1_y_r;
  logic signed [PW-1:0]        p_x_r, p_y_r;
  logic signed [QW-1:0]        qx, qy;
  logic signed [QW:0]          vx, vy;

  function automatic logic signed [OUT_BITS-1:0] sat(input logic signed [QW:0] v);
    logic signed [QW:0] t;
    t = v;
    if (v > LIM_HI) t = LIM_HI;
    if (v < LIM_LO) t = LIM_LO;
    return OUT_BITS'(t);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= CX_RESET;
      cy_r <= CY_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_CENTER_X) cx_r <= cfg_wdata;
      if (cfg_index == REG_CENTER_Y) cy_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
    end else begin
      s1_ctl_r <= pt_ctl;
      s2_ctl_r <= s1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_x_r <= pt_sx;
    s1_y_r <= pt_sy;
    p_x_r  <= PW'(s1_x_r) * PW'(COEF_Q15);
    p_y_r  <= PW'(s1_y_r) * PW'(COEF_Q15);
  end

  assign qx = ((QW'(p_x_r) + QW'(RND)) >>> SHR) <<< SHL;
  assign qy = ((QW'(p_y_r) + QW'(RND)) >>> SHR) <<< SHL;
  assign vx = (QW+1)'(qx) + (QW+1)'(cx_r);
  assign vy = (QW+1)'(qy) + (QW+1)'(cy_r);

  assign oq_push      = s2_ctl_r.valid;
  assign oq_word.x    = s2_ctl_r.fin ? '0 : sat(vx);
  assign oq_word.y    = s2_ctl_r.fin ? '0 : sat(vy);
  assign oq_word.last = s2_ctl_r.last;
  assign oq_word.fin  = s2_ctl_r.fin;
  assign busy         = {1'b0, s1_ctl_r.valid} + {1'b0, s2_ctl_r.valid};

endmodule
`default_nettype wire

### rtl/core/mer_oq.sv
// Result queue of the rasterizer, eight words deep.
// Depends on mer_pkg.
`default_nettype none
module mer_oq
  import mer_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             oq_push,
  input  out_word_t        oq_word,
  input  logic             pop,
  output logic             empty,
  output out_word_t        head,
  output logic [OCC_W-1:0] count
);

  localparam int PTR_W = $clog2(OQ_DEPTH);

  out_word_t        mem_r [OQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OCC_W-1:0] cnt_r;
  logic             rd_en;

  assign empty = (cnt_r == '0);
  assign rd_en = pop && !empty;
  assign head  = mem_r[rd_ptr_r];
  assign count = cnt_r;

  always_ff @(posedge clk) begin
    if (oq_push) mem_r[wr_ptr_r] <= oq_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (oq_push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (rd_en)   rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      cnt_r <= cnt_r + OCC_W'(oq_push) - OCC_W'(rd_en);
    end
  end

endmodule
`default_nettype wire

### rtl/core/midpoint_ellipse_rotated_rasterizer_top.sv
// Rotated midpoint ellipse rasterizer top level; depends on mer_pkg and its four sub-blocks.
// A start word runs the set-up states SQA, SQB, AB and INIT; a step word runs EMIT, UPA and UPB
// in region one, after CHK in region two, and after TX, TY, P1, P2, P3, RC and CHK on a change.
// No new word is taken before IDLE; a step's points pass mer_point's s1 and s2 registers.
// Synchronous active-low reset empties both queues and leaves no ellipse loaded.
`default_nettype none
module midpoint_ellipse_rotated_rasterizer_top
  import mer_pkg::*;
#(
  parameter int AXIS_WIDTH = AXIS_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic                       in_command,
  input  logic [AXIS_WIDTH-1:0]      in_semi_axis_a,
  input  logic [AXIS_WIDTH-1:0]      in_semi_axis_b,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [OUT_BITS-1:0] out_point_x,
  output logic signed [OUT_BITS-1:0] out_point_y,
  output logic                       out_last_of_run,
  output logic                       out_finished,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_index,
  input  logic [CFG_WIDTH-1:0]       cfg_wdata
);

  cmd_ctl_t                     cmd_ctl;
  logic [AXIS_WIDTH-1:0]        cmd_a, cmd_b;
  logic                         cmd_pop;
  pt_ctl_t                      pt_ctl;
  logic signed [AXIS_WIDTH+2:0] pt_sx, pt_sy;
  logic                         oq_push;
  out_word_t                    oq_word, head;
  logic [1:0]                   busy;
  logic [OCC_W-1:0]             count, occ;

  assign occ             = count + OCC_W'(busy);
  assign out_point_x     = head.x;
  assign out_point_y     = head.y;
  assign out_last_of_run = head.last;
  assign out_finished    = head.fin;

  mer_front #(.AXIS_WIDTH(AXIS_WIDTH)) u_front (
    .clk, .rst_n, .push, .full, .in_command, .in_semi_axis_a, .in_semi_axis_b,
    .cmd_pop, .cmd_ctl, .cmd_a, .cmd_b
  );

  mer_back #(.AXIS_WIDTH(AXIS_WIDTH)) u_back (
    .clk, .rst_n, .cmd_ctl, .cmd_a, .cmd_b, .cmd_pop, .occ, .pt_ctl, .pt_sx, .pt_sy
  );

  mer_point #(.AXIS_WIDTH(AXIS_WIDTH), .FRAC_BITS(FRAC_BITS)) u_point (
    .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_wdata, .pt_ctl, .pt_sx, .pt_sy,
    .oq_push, .oq_word, .busy
  );

  mer_oq u_oq (
    .clk, .rst_n, .oq_push, .oq_word, .pop, .empty, .head, .count
  );

endmodule
`default_nettype wire

### rtl/core/mer_checker.sv
// Port-level checks of the rasterizer top level, attached by a bind statement.
// Depends on mer_pkg and midpoint_ellipse_rotated_rasterizer_top.
`default_nettype none
module mer_checker
  import mer_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       full,
  input logic                       empty,
  input logic                       pop,
  input logic signed [OUT_BITS-1:0] out_point_x,
  input logic signed [OUT_BITS-1:0] out_point_y,
  input logic                       out_last_of_run,
  input logic                       out_finished
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_reset_not_full: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("command queue full after reset");

  a_finished_word: assert property (@(posedge clk)
      (!empty && out_finished) |->
      (out_point_x == '0 && out_point_y == '0 && !out_last_of_run))
    else $error("finished word carries a point");

  a_head_holds: assert property (@(posedge clk) disable iff (!rst_n)
      (!empty && !pop) |=> (!empty && $stable(out_point_x) && $stable(out_finished)))
    else $error("waiting result word changed");

endmodule

bind midpoint_ellipse_rotated_rasterizer_top mer_checker u_chk (.*);
`default_nettype wire
